### hw/rtl/isa_bus_target_interface_assert.svh
// Assertion macros shared by the ISA bus target RTL.
`ifndef ISA_BUS_TARGET_INTERFACE_ASSERT_SVH
`define ISA_BUS_TARGET_INTERFACE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define IBTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isa bus target: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IBTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isa bus target: next-cycle check failed");

`else

`define IBTI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IBTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/ibti_pkg.sv
// Types, codes and constants of the ISA bus target.
package ibti_pkg;

    localparam int ADDR_W            = 20;
    localparam int PORT_W            = 16;
    localparam int DMA_CHANNEL_COUNT = 3;
    localparam logic [2:0] OWNABLE_MASK = 3'((1 << DMA_CHANNEL_COUNT) - 1);

    // Input item kinds.
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_DMA_MASK   = 3'd0;
    localparam logic [2:0] REG_IO_BASE    = 3'd1;
    localparam logic [2:0] REG_IO_COUNT   = 3'd2;
    localparam logic [2:0] REG_MMIO_BASE  = 3'd3;
    localparam logic [2:0] REG_MMIO_SIZE  = 3'd4;

    // Event flag bits.
    localparam int EV_IO_WRITE   = 0;
    localparam int EV_IO_READ    = 1;
    localparam int EV_MMIO_WRITE = 2;
    localparam int EV_MMIO_READ  = 3;
    localparam int EV_DMA_READ   = 4;
    localparam int EV_DMA_DONE   = 5;

    // Pending flag bits.
    localparam int PEND_IOW  = 0;
    localparam int PEND_IOR  = 1;
    localparam int PEND_MEMW = 2;
    localparam int PEND_DACK = 3;

    // Strobe bits, active low.
    localparam int STB_IOR  = 0;
    localparam int STB_IOW  = 1;
    localparam int STB_MEMR = 2;
    localparam int STB_MEMW = 3;

    typedef struct packed {
        logic [2:0]  dma_channel_mask;
        logic [15:0] io_port_base;
        logic [10:0] io_port_count;
        logic [19:0] mmio_base;
        logic [20:0] mmio_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_in;
        logic [3:0]        strobes_n;
        logic [2:0]        dack_n;
        logic              terminal_count;
        logic [1:0]        dma_channel;
        logic [7:0]        core_read_data;
    } in_item_t;

    // Packed so that the first field sits in the highest bits.
    typedef struct packed {
        logic [2:0]        drq;
        logic [1:0]        event_channel;
        logic [7:0]        event_data;
        logic [ADDR_W-1:0] event_address;
        logic [5:0]        event_flags;
        logic [7:0]        sd_data;
        logic              sd_drive;
    } result_t;

endpackage

### hw/rtl/isa_bus_target_interface.sv
// Top level of the 8-bit ISA bus target: stream ports, input and result registers.
//
//  channel   | handshake                      | beat contents
//  ----------+--------------------------------+----------------------------------
//  s_axis    | s_axis_tvalid / s_axis_tready  | one bus sample or DMA start/stop
//  m_axis    | m_axis_tvalid / m_axis_tready  | one result per input beat
//  apb       | psel, penable, pwrite, pready  | five configuration registers
//
// One input beat gives one result beat via the input and result registers; a new
// beat is accepted every cycle while the output side is ready. The rate is set by
// the input register feeding one pass of decode logic into the result register.
// Reset (rst_n low, asynchronous) clears both stages, bus history and registers.
// A stalled output holds its result while the input register still takes one
// more beat; after that s_axis_tready drops until the output is taken.
`include "isa_bus_target_interface_assert.svh"

module isa_bus_target_interface
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0: address[19:0], data_in[27:20], strobes_n[31:28],
    // dack_n[34:32], terminal_count[35], dma_channel[37:36],
    // core_read_data[45:38], zero fill[47:46].
    input  logic [47:0] s_axis_tdata,
    // tuser, from bit 0: action[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, from bit 0: sd_drive[0], sd_data[8:1], event_flags[14:9],
    // event_address[34:15], event_data[42:35], event_channel[44:43], drq[47:45].
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                in_valid_reg, in_valid_next;
    ibti_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    ibti_pkg::result_t   out_data_reg;
    ibti_pkg::result_t   result;
    ibti_pkg::cfg_t      cfg;
    logic                in_accept;
    logic                advance;

    assign pready = 1'b1;

    ibti_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ibti_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.action         <= s_axis_tuser;
            in_item_reg.address        <= s_axis_tdata[19:0];
            in_item_reg.data_in        <= s_axis_tdata[27:20];
            in_item_reg.strobes_n      <= s_axis_tdata[31:28];
            in_item_reg.dack_n         <= s_axis_tdata[34:32];
            in_item_reg.terminal_count <= s_axis_tdata[35];
            in_item_reg.dma_channel    <= s_axis_tdata[37:36];
            in_item_reg.core_read_data <= s_axis_tdata[45:38];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `IBTI_ASSERT_NEXT(a_advance_lands, clk, rst_n, advance, out_valid_reg)
    `IBTI_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `IBTI_ASSERT_IMPL(a_ready_when_out_free, clk, rst_n, !out_valid_reg, s_axis_tready)

endmodule

### hw/rtl/ibti_cfg_regs.sv
// APB configuration registers of the ISA bus target.
module ibti_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output ibti_pkg::cfg_t      cfg
);

    ibti_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ibti_pkg::REG_DMA_MASK:  cfg_reg.dma_channel_mask <= pwdata[2:0];
                ibti_pkg::REG_IO_BASE:   cfg_reg.io_port_base     <= pwdata[15:0];
                ibti_pkg::REG_IO_COUNT:  cfg_reg.io_port_count    <= pwdata[10:0];
                ibti_pkg::REG_MMIO_BASE: cfg_reg.mmio_base        <= pwdata[19:0];
                ibti_pkg::REG_MMIO_SIZE: cfg_reg.mmio_size        <= pwdata[20:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ibti_pkg::REG_DMA_MASK:  prdata = {29'd0, cfg_reg.dma_channel_mask};
            ibti_pkg::REG_IO_BASE:   prdata = {16'd0, cfg_reg.io_port_base};
            ibti_pkg::REG_IO_COUNT:  prdata = {21'd0, cfg_reg.io_port_count};
            ibti_pkg::REG_MMIO_BASE: prdata = {12'd0, cfg_reg.mmio_base};
            ibti_pkg::REG_MMIO_SIZE: prdata = {11'd0, cfg_reg.mmio_size};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/ibti_core.sv
// Bus state, edge detection, window decode and DMA control for one sample a cycle while en is high.
`include "isa_bus_target_interface_assert.svh"

module ibti_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ibti_pkg::in_item_t   item,
    input  ibti_pkg::cfg_t       cfg,
    output ibti_pkg::result_t    result
);

    logic [3:0] strobe_prev_reg, strobe_prev_next;
    logic [2:0] dack_prev_reg, dack_prev_next;
    logic       tc_prev_reg, tc_prev_next;
    logic [3:0] pending_reg, pending_next;
    logic       bus_driven_reg, bus_driven_next;
    logic [7:0] latched_byte_reg, latched_byte_next;
    logic [7:0] sd_byte_reg, sd_byte_next;
    logic [1:0] active_channel_reg, active_channel_next;
    logic       block_seen_reg, block_seen_next;
    logic [2:0] drq_levels_reg, drq_levels_next;

    logic [2:0]  owned;
    logic [2:0]  dack_low;
    logic [15:0] port;
    logic [15:0] port_off;
    logic [19:0] mmio_off;
    logic        port_hit;
    logic        mmio_hit;
    logic        ior_low, iow_low, memr_low, memw_low;
    logic        ior_prev_low, iow_prev_low, memr_prev_low;
    logic        dma_at_entry;
    logic [5:0]  flags;
    logic [19:0] ev_addr;
    logic [7:0]  ev_data;
    logic [1:0]  ev_chan;
    logic        addr_set, chan_set;

    function automatic logic [2:0] chan_onehot(input logic [1:0] ch);
        case (ch)
            2'd1:    chan_onehot = 3'b001;
            2'd2:    chan_onehot = 3'b010;
            2'd3:    chan_onehot = 3'b100;
            default: chan_onehot = 3'b000;
        endcase
    endfunction

    assign owned    = cfg.dma_channel_mask & ibti_pkg::OWNABLE_MASK;
    assign dack_low = owned & ~item.dack_n;
    assign port     = item.address[15:0];
    assign port_off = port - cfg.io_port_base;
    assign mmio_off = item.address - cfg.mmio_base;
    assign port_hit = (port >= cfg.io_port_base)
                   && ({1'b0, port_off} < {6'd0, cfg.io_port_count});
    assign mmio_hit = (item.address >= cfg.mmio_base)
                   && ({1'b0, mmio_off} < cfg.mmio_size);

    assign ior_low       = !item.strobes_n[ibti_pkg::STB_IOR];
    assign iow_low       = !item.strobes_n[ibti_pkg::STB_IOW];
    assign memr_low      = !item.strobes_n[ibti_pkg::STB_MEMR];
    assign memw_low      = !item.strobes_n[ibti_pkg::STB_MEMW];
    assign ior_prev_low  = !strobe_prev_reg[ibti_pkg::STB_IOR];
    assign iow_prev_low  = !strobe_prev_reg[ibti_pkg::STB_IOW];
    assign memr_prev_low = !strobe_prev_reg[ibti_pkg::STB_MEMR];
    assign dma_at_entry  = active_channel_reg != 2'd0;

    // The block is written in the order the bus events are resolved; later
    // assignments override earlier ones within the same sample.
    always_comb
    begin
        strobe_prev_next    = strobe_prev_reg;
        dack_prev_next      = dack_prev_reg;
        tc_prev_next        = tc_prev_reg;
        pending_next        = pending_reg;
        bus_driven_next     = bus_driven_reg;
        latched_byte_next   = latched_byte_reg;
        sd_byte_next        = sd_byte_reg;
        active_channel_next = active_channel_reg;
        block_seen_next     = block_seen_reg;
        drq_levels_next     = drq_levels_reg;
        flags    = '0;
        ev_addr  = '0;
        ev_data  = '0;
        ev_chan  = '0;
        addr_set = 1'b0;
        chan_set = 1'b0;

        case (item.action) inside
            ibti_pkg::ACT_START, ibti_pkg::ACT_STOP:
            begin
                if ((owned & chan_onehot(item.dma_channel)) != 3'b000)
                begin
                    if (item.action == ibti_pkg::ACT_START)
                    begin
                        active_channel_next = item.dma_channel;
                        drq_levels_next     = drq_levels_reg | chan_onehot(item.dma_channel);
                    end
                    else
                    begin
                        active_channel_next = 2'd0;
                        drq_levels_next     = drq_levels_reg & ~chan_onehot(item.dma_channel);
                    end
                end
            end
            ibti_pkg::ACT_SAMPLE:
            begin
                // Single-mode DMA read served one sample after DACK fell.
                if (pending_reg[ibti_pkg::PEND_DACK])
                begin
                    pending_next[ibti_pkg::PEND_DACK] = 1'b0;
                    bus_driven_next = 1'b1;
                    sd_byte_next    = item.core_read_data;
                    flags[ibti_pkg::EV_DMA_READ] = 1'b1;
                    ev_chan         = active_channel_reg;
                    chan_set        = 1'b1;
                    block_seen_next = 1'b0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (dack_low[i] && dack_prev_reg[i] && active_channel_reg == 2'(i + 1))
                    begin
                        pending_next[ibti_pkg::PEND_DACK] = 1'b1;
                    end
                    if (!dack_low[i] && !dack_prev_reg[i])
                    begin
                        bus_driven_next = 1'b0;
                        sd_byte_next    = 8'd0;
                    end
                end
                dack_prev_next = ~dack_low;

                // Block mode: every IOR falling edge after the first is a read.
                if (dma_at_entry && ior_low && !ior_prev_low
                    && (dack_low & chan_onehot(active_channel_reg)) != 3'b000)
                begin
                    if (block_seen_reg)
                    begin
                        bus_driven_next = 1'b1;
                        sd_byte_next    = item.core_read_data;
                        flags[ibti_pkg::EV_DMA_READ] = 1'b1;
                        if (!chan_set)
                        begin
                            ev_chan  = active_channel_reg;
                            chan_set = 1'b1;
                        end
                    end
                    block_seen_next = 1'b1;
                end

                if (item.terminal_count && !tc_prev_reg && dma_at_entry)
                begin
                    active_channel_next = 2'd0;
                    drq_levels_next = drq_levels_next & ~chan_onehot(active_channel_reg);
                    flags[ibti_pkg::EV_DMA_DONE] = 1'b1;
                    if (!chan_set)
                    begin
                        ev_chan  = active_channel_reg;
                        chan_set = 1'b1;
                    end
                end
                tc_prev_next = item.terminal_count;

                if (!dma_at_entry)
                begin
                    if (pending_reg[ibti_pkg::PEND_IOW])
                    begin
                        if (port_hit)
                        begin
                            flags[ibti_pkg::EV_IO_WRITE] = 1'b1;
                            ev_addr  = {4'd0, port};
                            addr_set = 1'b1;
                            ev_data  = item.data_in;
                        end
                        pending_next[ibti_pkg::PEND_IOW] = 1'b0;
                    end
                    else if (iow_low && !iow_prev_low)
                    begin
                        pending_next[ibti_pkg::PEND_IOW] = 1'b1;
                    end

                    if (pending_reg[ibti_pkg::PEND_IOR])
                    begin
                        if (dack_low == 3'b000 && port_hit)
                        begin
                            latched_byte_next = item.core_read_data;
                            bus_driven_next   = 1'b1;
                            sd_byte_next      = item.core_read_data;
                            flags[ibti_pkg::EV_IO_READ] = 1'b1;
                            if (!addr_set)
                            begin
                                ev_addr  = {4'd0, port};
                                addr_set = 1'b1;
                            end
                        end
                        pending_next[ibti_pkg::PEND_IOR] = 1'b0;
                    end
                    else if (ior_low && !ior_prev_low)
                    begin
                        pending_next[ibti_pkg::PEND_IOR] = 1'b1;
                    end
                    else if (active_channel_next == 2'd0)
                    begin
                        // Hold the latched byte while IOR stays low, release after.
                        if (ior_low && bus_driven_next)
                        begin
                            sd_byte_next = latched_byte_next;
                        end
                        else if (!ior_low && bus_driven_next)
                        begin
                            bus_driven_next = 1'b0;
                            sd_byte_next    = 8'd0;
                        end
                    end

                    if (pending_reg[ibti_pkg::PEND_MEMW])
                    begin
                        if (mmio_hit)
                        begin
                            flags[ibti_pkg::EV_MMIO_WRITE] = 1'b1;
                            if (!addr_set)
                            begin
                                ev_addr  = item.address;
                                addr_set = 1'b1;
                            end
                            if (!flags[ibti_pkg::EV_IO_WRITE])
                            begin
                                ev_data = item.data_in;
                            end
                        end
                        pending_next[ibti_pkg::PEND_MEMW] = 1'b0;
                    end
                    else if (memw_low && !strobe_prev_reg[ibti_pkg::STB_MEMW] == 1'b0
                             && mmio_hit)
                    begin
                        pending_next[ibti_pkg::PEND_MEMW] = 1'b1;
                    end

                    if (memr_low)
                    begin
                        if (mmio_hit)
                        begin
                            bus_driven_next = 1'b1;
                            sd_byte_next    = item.core_read_data;
                            flags[ibti_pkg::EV_MMIO_READ] = 1'b1;
                            if (!addr_set)
                            begin
                                ev_addr  = item.address;
                                addr_set = 1'b1;
                            end
                        end
                    end
                    else if (memr_prev_low)
                    begin
                        bus_driven_next = 1'b0;
                        sd_byte_next    = 8'd0;
                    end
                    strobe_prev_next = item.strobes_n;
                end
                else
                begin
                    // During DMA only the IOR and IOW history moves.
                    strobe_prev_next = {strobe_prev_reg[3:2], item.strobes_n[1:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.sd_drive      = bus_driven_next;
        result.sd_data       = bus_driven_next ? sd_byte_next : 8'd0;
        result.event_flags   = flags;
        result.event_address = ev_addr;
        result.event_data    = ev_data;
        result.event_channel = ev_chan;
        result.drq           = drq_levels_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_prev_reg    <= 4'hF;
            dack_prev_reg      <= 3'h7;
            tc_prev_reg        <= 1'b0;
            pending_reg        <= '0;
            bus_driven_reg     <= 1'b0;
            latched_byte_reg   <= '0;
            sd_byte_reg        <= '0;
            active_channel_reg <= '0;
            block_seen_reg     <= 1'b0;
            drq_levels_reg     <= '0;
        end
        else if (en)
        begin
            strobe_prev_reg    <= strobe_prev_next;
            dack_prev_reg      <= dack_prev_next;
            tc_prev_reg        <= tc_prev_next;
            pending_reg        <= pending_next;
            bus_driven_reg     <= bus_driven_next;
            latched_byte_reg   <= latched_byte_next;
            sd_byte_reg        <= sd_byte_next;
            active_channel_reg <= active_channel_next;
            block_seen_reg     <= block_seen_next;
            drq_levels_reg     <= drq_levels_next;
        end
    end

    `IBTI_ASSERT_IMPL(a_active_has_drq, clk, rst_n, active_channel_reg != 2'd0, (drq_levels_reg & chan_onehot(active_channel_reg)) != 3'b000)
    `IBTI_ASSERT_IMPL(a_released_is_zero, clk, rst_n, !bus_driven_reg, sd_byte_reg == 8'd0)
    `IBTI_ASSERT_NEXT(a_state_holds, clk, rst_n, !en, $stable(drq_levels_reg) && $stable(active_channel_reg) && $stable(pending_reg))

endmodule

### tb/testbench.sv
// Self-checking testbench for the ISA bus target with directed and random bus traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the target's bus state and queues the response each input beat should produce.
    class target_scoreboard;
        logic [2:0]  dma_mask;
        logic [15:0] io_base;
        logic [10:0] io_count;
        logic [19:0] mm_base;
        logic [20:0] mm_size;

        logic [3:0]  stb_hist;
        logic [2:0]  dack_hist;
        logic        tc_hist;
        logic [3:0]  waiting;
        bit          bus_on;
        logic [7:0]  read_latch;
        logic [7:0]  bus_byte;
        logic [1:0]  dma_ch;
        bit          burst_armed;
        logic [2:0]  drq_lvl;

        ibti_pkg::result_t bus_responses[$];
        int          errors;

        function new();
            dma_mask = '0;
            io_base = '0;
            io_count = '0;
            mm_base = '0;
            mm_size = '0;
            stb_hist = 4'hF;
            dack_hist = 3'h7;
            tc_hist = 1'b0;
            waiting = '0;
            bus_on = 0;
            read_latch = '0;
            bus_byte = '0;
            dma_ch = '0;
            burst_armed = 0;
            drq_lvl = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                ibti_pkg::REG_DMA_MASK:  dma_mask = v[2:0];
                ibti_pkg::REG_IO_BASE:   io_base = v[15:0];
                ibti_pkg::REG_IO_COUNT:  io_count = v[10:0];
                ibti_pkg::REG_MMIO_BASE: mm_base = v[19:0];
                ibti_pkg::REG_MMIO_SIZE: mm_size = v[20:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return bus_responses.size();
        endfunction

        function bit channel_owned(int ch);
            return ch >= 1 && ch <= ibti_pkg::DMA_CHANNEL_COUNT && dma_mask[ch-1];
        endfunction

        // Port windows never wrap past the top of the 16-bit port space.
        function bit in_port_window(logic [15:0] p);
            return p >= io_base && (32'(p) - 32'(io_base)) < 32'(io_count);
        endfunction

        function bit in_mem_window(logic [19:0] a);
            return a >= mm_base && (32'(a) - 32'(mm_base)) < 32'(mm_size);
        endfunction

        function void put_bus(logic [7:0] v);
            bus_byte = v;
            bus_on = 1;
        endfunction

        function void drop_bus();
            bus_byte = '0;
            bus_on = 0;
        endfunction

        function void note_beat(ibti_pkg::in_item_t it);
            ibti_pkg::result_t r;
            logic [5:0]  flags;
            logic [19:0] ev_addr;
            logic [7:0]  ev_data;
            logic [1:0]  ev_chan;
            bit          addr_set;
            bit          chan_set;
            bit          dma_at_entry;
            bit          cur;
            bit          prev;
            logic [3:0]  stb;
            logic [2:0]  dack_low;
            logic [15:0] port;
            int          ch;

            flags = '0;
            ev_addr = '0;
            ev_data = '0;
            ev_chan = '0;
            addr_set = 0;
            chan_set = 0;
            stb = it.strobes_n;
            port = it.address[15:0];

            if (it.action == ibti_pkg::ACT_START || it.action == ibti_pkg::ACT_STOP) begin
                if (channel_owned(int'(it.dma_channel))) begin
                    if (it.action == ibti_pkg::ACT_START) begin
                        dma_ch = it.dma_channel;
                        drq_lvl[int'(it.dma_channel) - 1] = 1'b1;
                    end
                    else begin
                        dma_ch = '0;
                        drq_lvl[int'(it.dma_channel) - 1] = 1'b0;
                    end
                end
            end
            else if (it.action == ibti_pkg::ACT_SAMPLE) begin
                dma_at_entry = dma_ch != 0;
                dack_low = '0;
                for (ch = 1; ch <= 3; ch++)
                    if (channel_owned(ch) && !it.dack_n[ch-1])
                        dack_low[ch-1] = 1'b1;

                // A DACK that fell on the previous sample is served now.
                if (waiting[ibti_pkg::PEND_DACK]) begin
                    waiting[ibti_pkg::PEND_DACK] = 1'b0;
                    put_bus(it.core_read_data);
                    flags[ibti_pkg::EV_DMA_READ] = 1'b1;
                    ev_chan = dma_ch;
                    chan_set = 1;
                    burst_armed = 0;
                end
                for (ch = 1; ch <= 3; ch++) begin
                    cur = dack_low[ch-1];
                    prev = !dack_hist[ch-1];
                    if (cur && !prev && int'(dma_ch) == ch)
                        waiting[ibti_pkg::PEND_DACK] = 1'b1;
                    if (!cur && prev)
                        drop_bus();
                end
                dack_hist = ~dack_low;

                // Block mode: every IOR fall after the first one under DACK reads a byte.
                if (dma_ch != 0 && !stb[ibti_pkg::STB_IOR] && stb_hist[ibti_pkg::STB_IOR]) begin
                    if (dack_low[int'(dma_ch) - 1]) begin
                        if (burst_armed) begin
                            put_bus(it.core_read_data);
                            flags[ibti_pkg::EV_DMA_READ] = 1'b1;
                            if (!chan_set) begin
                                ev_chan = dma_ch;
                                chan_set = 1;
                            end
                        end
                        burst_armed = 1;
                    end
                end

                if (it.terminal_count && !tc_hist && dma_ch != 0) begin
                    drq_lvl[int'(dma_ch) - 1] = 1'b0;
                    flags[ibti_pkg::EV_DMA_DONE] = 1'b1;
                    if (!chan_set) begin
                        ev_chan = dma_ch;
                        chan_set = 1;
                    end
                    dma_ch = '0;
                end
                tc_hist = it.terminal_count;

                if (!dma_at_entry) begin
                    if (waiting[ibti_pkg::PEND_IOW]) begin
                        if (in_port_window(port)) begin
                            flags[ibti_pkg::EV_IO_WRITE] = 1'b1;
                            ev_addr = 20'(port);
                            addr_set = 1;
                            ev_data = it.data_in;
                        end
                        waiting[ibti_pkg::PEND_IOW] = 1'b0;
                    end
                    else if (!stb[ibti_pkg::STB_IOW] && stb_hist[ibti_pkg::STB_IOW])
                        waiting[ibti_pkg::PEND_IOW] = 1'b1;

                    if (waiting[ibti_pkg::PEND_IOR]) begin
                        if (dack_low == 0 && in_port_window(port)) begin
                            read_latch = it.core_read_data;
                            put_bus(it.core_read_data);
                            flags[ibti_pkg::EV_IO_READ] = 1'b1;
                            if (!addr_set) begin
                                ev_addr = 20'(port);
                                addr_set = 1;
                            end
                        end
                        waiting[ibti_pkg::PEND_IOR] = 1'b0;
                    end
                    else if (!stb[ibti_pkg::STB_IOR] && stb_hist[ibti_pkg::STB_IOR])
                        waiting[ibti_pkg::PEND_IOR] = 1'b1;
                    else if (dma_ch == 0) begin
                        if (!stb[ibti_pkg::STB_IOR] && bus_on)
                            put_bus(read_latch);
                        else if (stb[ibti_pkg::STB_IOR] && bus_on)
                            drop_bus();
                    end

                    if (waiting[ibti_pkg::PEND_MEMW]) begin
                        if (in_mem_window(it.address)) begin
                            flags[ibti_pkg::EV_MMIO_WRITE] = 1'b1;
                            if (!addr_set) begin
                                ev_addr = it.address;
                                addr_set = 1;
                            end
                            if (!flags[ibti_pkg::EV_IO_WRITE])
                                ev_data = it.data_in;
                        end
                        waiting[ibti_pkg::PEND_MEMW] = 1'b0;
                    end
                    else if (!stb[ibti_pkg::STB_MEMW] && stb_hist[ibti_pkg::STB_MEMW]
                             && in_mem_window(it.address))
                        waiting[ibti_pkg::PEND_MEMW] = 1'b1;

                    if (!stb[ibti_pkg::STB_MEMR]) begin
                        if (in_mem_window(it.address)) begin
                            put_bus(it.core_read_data);
                            flags[ibti_pkg::EV_MMIO_READ] = 1'b1;
                            if (!addr_set) begin
                                ev_addr = it.address;
                                addr_set = 1;
                            end
                        end
                    end
                    else if (!stb_hist[ibti_pkg::STB_MEMR])
                        drop_bus();
                    stb_hist = stb;
                end
                else begin
                    // Only the I/O strobe history moves while a DMA owns the bus.
                    stb_hist = {stb_hist[3:2], stb[1:0]};
                end
            end

            r.sd_drive = bus_on;
            r.sd_data = bus_on ? bus_byte : 8'h00;
            r.event_flags = flags;
            r.event_address = ev_addr;
            r.event_data = ev_data;
            r.event_channel = ev_chan;
            r.drq = drq_lvl;
            bus_responses.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] beat);
            ibti_pkg::result_t got;
            ibti_pkg::result_t want;
            got = ibti_pkg::result_t'(beat);
            if (bus_responses.size() == 0) begin
                $error("result beat arrived with no input beat waiting for it");
                errors++;
                return;
            end
            want = bus_responses.pop_front();
            compare_field("sd_drive", 32'(want.sd_drive), 32'(got.sd_drive));
            compare_field("sd_data", 32'(want.sd_data), 32'(got.sd_data));
            compare_field("event_flags", 32'(want.event_flags), 32'(got.event_flags));
            compare_field("event_address", 32'(want.event_address), 32'(got.event_address));
            compare_field("event_data", 32'(want.event_data), 32'(got.event_data));
            compare_field("event_channel", 32'(want.event_channel), 32'(got.event_channel));
            compare_field("drq", 32'(want.drq), 32'(got.drq));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata, from bit 0: address, data_in, strobes_n, dack_n, terminal_count,
    // dma_channel, core_read_data, zero fill.
    logic [47:0] s_axis_tdata;
    // tuser, from bit 0: action.
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata, from bit 0: sd_drive, sd_data, event_flags, event_address,
    // event_data, event_channel, drq.
    logic [47:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    target_scoreboard sb;

    int unsigned cfg_mask;
    int unsigned cfg_io_base;
    int unsigned cfg_io_count;
    int unsigned cfg_mm_base;
    int unsigned cfg_mm_size;

    int beats_sent = 0;
    bit src_idle_on = 0;
    bit sink_idle_on = 0;
    bit long_hold_req = 0;

    isa_bus_target_interface uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Output side: random stalls, plus one long hold on request to back up the pipeline.
    initial
    begin : sink
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                m_axis_tready = 1'b0;
                repeat (63) @(negedge clk);
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    initial
    begin
        #3_000_000;
        $display("isa_bus_target_interface test failed");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(int unsigned m, int unsigned iob, int unsigned ioc,
                             int unsigned mmb, int unsigned mms);
        cfg_mask = m;
        cfg_io_base = iob;
        cfg_io_count = ioc;
        cfg_mm_base = mmb;
        cfg_mm_size = mms;
        write_reg(ibti_pkg::REG_DMA_MASK, m);
        write_reg(ibti_pkg::REG_IO_BASE, iob);
        write_reg(ibti_pkg::REG_IO_COUNT, ioc);
        write_reg(ibti_pkg::REG_MMIO_BASE, mmb);
        write_reg(ibti_pkg::REG_MMIO_SIZE, mms);
    endtask

    // The last beat stays on the bus after its handshake, so withdraw it first.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic send_beat(ibti_pkg::in_item_t it);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.action;
        s_axis_tdata = {2'b00, it.core_read_data, it.dma_channel, it.terminal_count,
                        it.dack_n, it.strobes_n, it.data_in, it.address};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_beat(it);
        beats_sent++;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    endtask

    task automatic sample(logic [19:0] a, logic [7:0] d, logic [3:0] stb, logic [2:0] dk,
                          logic tc, logic [7:0] core);
        ibti_pkg::in_item_t it;
        it.action = ibti_pkg::ACT_SAMPLE;
        it.address = a;
        it.data_in = d;
        it.strobes_n = stb;
        it.dack_n = dk;
        it.terminal_count = tc;
        it.dma_channel = 2'($urandom_range(1, 3));
        it.core_read_data = core;
        send_beat(it);
    endtask

    task automatic dma_cmd(logic [1:0] act, logic [1:0] ch);
        ibti_pkg::in_item_t it;
        it.action = act;
        it.address = 20'($urandom);
        it.data_in = 8'($urandom);
        it.strobes_n = 4'($urandom);
        it.dack_n = 3'($urandom);
        it.terminal_count = 1'($urandom);
        it.dma_channel = ch;
        it.core_read_data = 8'($urandom);
        send_beat(it);
    endtask

    // Addresses mostly land inside or at the edges of the claimed windows.
    function automatic logic [19:0] pick_addr();
        int unsigned k;
        logic [19:0] a;
        k = $urandom_range(0, 9);
        a = 20'($urandom);
        if (k < 3 && cfg_io_count != 0)
            a[15:0] = 16'(cfg_io_base + $urandom_range(0, cfg_io_count - 1));
        else if (k == 3)
            a[15:0] = 16'($urandom_range(0, 1) ? cfg_io_base + cfg_io_count : cfg_io_base - 1);
        else if (k >= 4 && k < 7 && cfg_mm_size != 0)
            a = 20'(cfg_mm_base + $urandom_range(0, cfg_mm_size - 1));
        else if (k == 7)
            a = 20'($urandom_range(0, 1) ? cfg_mm_base + cfg_mm_size : cfg_mm_base - 1);
        return a;
    endfunction

    function automatic logic [1:0] pick_channel();
        logic [1:0] ch;
        ch = 2'($urandom_range(1, 3));
        if (cfg_mask != 0 && $urandom_range(0, 3) != 0)
            while (cfg_mask[ch-1] == 1'b0)
                ch = (ch == 2'd3) ? 2'd1 : ch + 2'd1;
        return ch;
    endfunction

    // One CPU cycle: idle, a strobe held low for a few samples, then released.
    task automatic cpu_cycle();
        int         n;
        int         i;
        logic [19:0] a;
        logic [7:0]  d;
        logic [3:0]  stb;
        a = pick_addr();
        d = 8'($urandom);
        stb = 4'hF;
        stb[$urandom_range(0, 3)] = 1'b0;
        n = $urandom_range(1, 4);
        sample(a, 8'($urandom), 4'hF, 3'h7, 1'b0, 8'($urandom));
        for (i = 0; i < n; i++)
            sample(a, d, stb, 3'h7, 1'b0, 8'($urandom));
        sample(a, d, 4'hF, 3'h7, 1'b0, 8'($urandom));
    endtask

    task automatic dma_transfer();
        logic [1:0]  ch;
        logic [2:0]  dk;
        logic [19:0] a;
        int          n;
        int          i;
        int          j;
        ch = pick_channel();
        dk = ~(3'b001 << (ch - 2'd1));
        a = pick_addr();
        n = $urandom_range(1, 4);
        dma_cmd(ibti_pkg::ACT_START, ch);
        if ($urandom_range(0, 1))
        begin
            // Single mode: one byte per DACK fall.
            for (i = 0; i < n; i++)
            begin
                sample(a, 8'($urandom), 4'hF, 3'h7, 1'b0, 8'($urandom));
                for (j = $urandom_range(1, 3); j > 0; j--)
                    sample(a, 8'($urandom), {3'b111, 1'($urandom)}, dk, 1'b0, 8'($urandom));
            end
        end
        else
        begin
            // Block mode: DACK stays low while IOR pulses.
            sample(a, 8'($urandom), 4'hF, dk, 1'b0, 8'($urandom));
            for (i = 0; i <= n; i++)
            begin
                sample(a, 8'($urandom), 4'hE, dk, 1'b0, 8'($urandom));
                sample(a, 8'($urandom), 4'hF, dk, 1'b0, 8'($urandom));
            end
        end
        case ($urandom_range(0, 3))
            0, 1:
            begin
                if ($urandom_range(0, 1))
                    sample(a, 8'($urandom), 4'hF, 3'h7, 1'b0, 8'($urandom));
                sample(a, 8'($urandom), 4'hF, dk, 1'b1, 8'($urandom));
                sample(a, 8'($urandom), 4'hF, 3'h7, 1'b0, 8'($urandom));
            end
            2: dma_cmd(ibti_pkg::ACT_STOP, ch);
            default: ;
        endcase
        sample(a, 8'($urandom), 4'hF, 3'h7, 1'b0, 8'($urandom));
    endtask

    task automatic random_step();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            cpu_cycle();
        else if (k < 70)
            dma_transfer();
        else if (k < 88)
            sample(pick_addr(), 8'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
                   8'($urandom));
        else if (k < 98)
            dma_cmd($urandom_range(0, 1) ? ibti_pkg::ACT_START : ibti_pkg::ACT_STOP,
                    pick_channel());
        else
            drain();
    endtask

    // Runs with ports 0x300..0x30F and memory 0xC8000..0xCBFFF claimed, all channels owned.
    task automatic directed_items();
        sample(20'h00000, 8'h00, 4'hF, 3'h7, 1'b0, 8'h00);
        sample(20'hF0300, 8'hFF, 4'hD, 3'h7, 1'b0, 8'hFF);
        sample(20'hF0300, 8'hFF, 4'hF, 3'h7, 1'b0, 8'h00);
        sample(20'h0030F, 8'h00, 4'hE, 3'h7, 1'b0, 8'h11);
        sample(20'h0030F, 8'h00, 4'hE, 3'h7, 1'b0, 8'hA5);
        sample(20'h0030F, 8'h00, 4'hE, 3'h7, 1'b0, 8'h3C);
        sample(20'h00310, 8'h00, 4'hF, 3'h7, 1'b0, 8'h00);
        sample(20'hC8000, 8'h5A, 4'h7, 3'h7, 1'b0, 8'h00);
        sample(20'hC8000, 8'h5A, 4'hF, 3'h7, 1'b0, 8'h00);
        sample(20'hCBFFF, 8'h00, 4'hB, 3'h7, 1'b0, 8'hFF);
        sample(20'hCC000, 8'h00, 4'hB, 3'h7, 1'b0, 8'hFF);
        sample(20'hFFFFF, 8'hFF, 4'hF, 3'h7, 1'b0, 8'h00);
        // Single-mode read on channel 2, then a block-mode read, ended by T/C.
        dma_cmd(ibti_pkg::ACT_START, 2'd2);
        sample(20'h00000, 8'h00, 4'hF, 3'b101, 1'b0, 8'h77);
        sample(20'h00000, 8'h00, 4'hF, 3'b101, 1'b0, 8'h88);
        sample(20'h00000, 8'h00, 4'hE, 3'b101, 1'b0, 8'h99);
        sample(20'h00000, 8'h00, 4'hF, 3'b101, 1'b0, 8'h00);
        sample(20'h00000, 8'h00, 4'hE, 3'b101, 1'b0, 8'hC3);
        sample(20'h00000, 8'h00, 4'hF, 3'b101, 1'b1, 8'h00);
        sample(20'h00000, 8'h00, 4'hF, 3'h7, 1'b0, 8'h00);
        // DACK falls together with T/C: the read still happens, with no channel.
        dma_cmd(ibti_pkg::ACT_START, 2'd3);
        sample(20'h00000, 8'h00, 4'hF, 3'b011, 1'b1, 8'h42);
        sample(20'h00000, 8'h00, 4'hF, 3'b011, 1'b0, 8'h24);
        dma_cmd(ibti_pkg::ACT_START, 2'd1);
        dma_cmd(ibti_pkg::ACT_STOP, 2'd1);
        sample(20'hFFFFF, 8'hFF, 4'hF, 3'h7, 1'b0, 8'hFF);
    endtask

    initial
    begin
        int ph;
        int target;
        int next_shuffle;

        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ibti_pkg::ACT_SAMPLE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (ph = 0; ph < 7; ph++)
        begin
            drain();
            case (ph)
                0: configure(7, 16'h0300, 16, 20'hC8000, 21'h04000);
                1: configure(7, 0, 1024, 0, 21'h100000);
                2: configure(0, 16'hFFFF, 1024, 20'hFFFFF, 21'h100000);
                3: configure(5, $urandom_range(0, 16'hFFFF), 0, $urandom_range(0, 20'hFFFFF), 0);
                4: configure(2, 16'hFFF0, 1024, 20'hF0000, 21'h10000);
                default: configure($urandom_range(1, 7), $urandom_range(0, 16'hFFFF),
                                   $urandom_range(1, 1024), $urandom_range(0, 20'hFFFFF),
                                   $urandom_range(1, 21'h10000));
            endcase
            if (ph == 0)
                directed_items();
            if (ph == 2)
            begin
                // Keep offering beats while the output side holds off.
                src_idle_on = 0;
                long_hold_req = 1;
                repeat (6) cpu_cycle();
            end
            target = beats_sent + 112;
            next_shuffle = beats_sent;
            while (beats_sent < target)
            begin
                if (ph == 6)
                begin
                    src_idle_on = 0;
                    sink_idle_on = 0;
                end
                else if (beats_sent >= next_shuffle)
                begin
                    src_idle_on = $urandom_range(0, 2) != 0;
                    sink_idle_on = $urandom_range(0, 2) != 0;
                    next_shuffle = beats_sent + 40;
                end
                random_step();
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("isa_bus_target_interface test passed");
        else
            $display("isa_bus_target_interface test failed");
        $finish;
    end

endmodule
